>>> rtl/vn_pkg.sv
// ---------------------------------------------------------------------------
// vn_pkg
// Shared widths and pipeline latencies for the vector normalizer.
// ---------------------------------------------------------------------------
package vn_pkg;
  localparam int COMP_W   = 16;  // input component width
  localparam int MAG_W    = 16;  // component magnitude width
  localparam int SQ_W     = 32;  // square / sum of squares width
  localparam int LEN_W    = 16;  // vector length width
  localparam int Q_W      = 15;  // unsigned quotient width (max 16384)
  localparam int FRAC_W   = 15;  // one plus fraction bits of the rounded quotient
  localparam int SQRT_LAT = 16;  // square root stages
  localparam int DIV_LAT  = 16;  // divider setup plus quotient stages
endpackage

>>> rtl/vn_sqrt.sv
// ---------------------------------------------------------------------------
// vn_sqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ---------------------------------------------------------------------------
module vn_sqrt (
  input  logic                     clk,
  input  logic                     en,
  input  logic [vn_pkg::SQ_W-1:0]  sum,
  output logic [vn_pkg::LEN_W-1:0] root
);
  import vn_pkg::*;

  logic [SQ_W-1:0] rem_r  [1:SQRT_LAT];
  logic [SQ_W-1:0] root_r [1:SQRT_LAT];

  // one compare and subtract per stage
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] rem_cur;
    logic [SQ_W-1:0] root_cur;
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] rem_nxt;
    logic [SQ_W-1:0] root_nxt;

    // stage zero is the incoming sum
    if (k == 0) begin : g_first
      assign rem_cur  = sum;
      assign root_cur = '0;
    end else begin : g_next
      assign rem_cur  = rem_r[k];
      assign root_cur = root_r[k];
    end

    always_comb begin
      trial = root_cur + Bit;
      if (rem_cur >= trial) begin
        rem_nxt  = rem_cur - trial;
        root_nxt = (root_cur >> 1) + Bit;
      end else begin
        rem_nxt  = rem_cur;
        root_nxt = root_cur >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
      end
    end
  end

  assign root = root_r[SQRT_LAT][LEN_W-1:0];
endmodule

>>> rtl/vn_div_lane.sv
// ---------------------------------------------------------------------------
// vn_div_lane
// Pipelined restoring divider for one component: round(mag * 16384 / len).
// ---------------------------------------------------------------------------
module vn_div_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [vn_pkg::MAG_W-1:0] mag,
  input  logic [vn_pkg::LEN_W-1:0] len,
  output logic [vn_pkg::Q_W-1:0]   quo
);
  import vn_pkg::*;

  localparam int NUM_W = MAG_W + FRAC_W;   // rounded numerator width
  localparam int DEN_W = LEN_W + 1;        // doubled length width
  localparam int STEPS = DIV_LAT - 1;

  logic [DEN_W-1:0]  den_r [0:STEPS];
  logic [DEN_W-1:0]  rem_r [0:STEPS];
  logic [FRAC_W-1:0] low_r [0:STEPS];
  logic [Q_W-1:0]    quo_r [0:STEPS];
  logic [NUM_W-1:0]  num;

  // numerator mag*2^15 + len, high part is already below the divisor
  assign num = {mag, {FRAC_W{1'b0}}} + NUM_W'(len);

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= {len, 1'b0};
      rem_r[0] <= DEN_W'(num[NUM_W-1:FRAC_W]);
      low_r[0] <= num[FRAC_W-1:0];
      quo_r[0] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [DEN_W:0]   shifted;
    logic [DEN_W-1:0] rem_nxt;
    logic             qbit;

    always_comb begin
      shifted = {rem_r[k], low_r[k][FRAC_W-1]};
      qbit    = shifted >= {1'b0, den_r[k]};
      rem_nxt = qbit ? DEN_W'(shifted - {1'b0, den_r[k]}) : shifted[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1] <= den_r[k];
        rem_r[k+1] <= rem_nxt;
        low_r[k+1] <= low_r[k] << 1;
        quo_r[k+1] <= {quo_r[k][Q_W-2:0], qbit};
      end
    end
  end

  assign quo = quo_r[STEPS];
endmodule

>>> rtl/vector3_normalize.sv
// ---------------------------------------------------------------------------
// vector3_normalize
// Normalizes a signed 3D vector to Q2.14 with round-to-nearest quotients.
// ---------------------------------------------------------------------------
//  channel | direction | tdata                          | tuser
//  in_     | slave     | comp_x, comp_y, comp_z         | -
//  out_    | master    | unit_x, unit_y, unit_z         | zero_length
//
//  one beat accepted per cycle while not stalled; the output beat passes 35
//  register stages, counting the one that captures the input: square, sum,
//  16 root stages, 16 divider stages, output register
//  the whole pipeline stalls only while the output beat is held
//  rst_n clears the valid bits and holds in_tready low; payload registers
//  are not reset
// ---------------------------------------------------------------------------
module vector3_normalize (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // comp_x[15:0], comp_y[31:16], comp_z[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // unit_x[15:0], unit_y[31:16], unit_z[47:32]
  output logic        out_tuser   // zero_length
);
  import vn_pkg::*;

  localparam int LANES = 3;
  localparam int MID   = SQRT_LAT + DIV_LAT;

  logic                en;
  logic [MID+1:0]      vld_r;
  logic                out_vld_r;
  logic [47:0]         out_data_r;
  logic                out_zero_r;

  logic [MAG_W-1:0]    mag1_r [LANES];
  logic                sgn1_r [LANES];
  logic [SQ_W-1:0]     sq1_r  [LANES];
  logic [SQ_W-1:0]     sum2_r;
  logic                zero2_r;
  logic [MAG_W-1:0]    magd_r [LANES][0:SQRT_LAT];
  logic                sgnd_r [LANES][0:MID];
  logic                zerod_r [0:MID-1];
  logic [LEN_W-1:0]    len;
  logic [Q_W-1:0]      quo [LANES];
  logic [47:0]         out_data_nxt;

  // pipeline moves whenever the output slot is free or being taken
  assign en        = !out_vld_r || out_tready;
  assign in_tready = rst_n && en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[MID:0], in_tvalid};
      out_vld_r <= vld_r[MID+1];
    end
  end

  // per-lane magnitude, sign and square
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [COMP_W-1:0] comp;
    logic [MAG_W-1:0]         mag;

    assign comp = in_tdata[l*COMP_W +: COMP_W];
    assign mag  = comp[COMP_W-1] ? MAG_W'(-comp) : MAG_W'(comp);

    always_ff @(posedge clk) begin
      if (en) begin
        mag1_r[l] <= mag;
        sgn1_r[l] <= comp[COMP_W-1];
        sq1_r[l]  <= SQ_W'(mag) * SQ_W'(mag);
      end
    end

    // magnitude waits for the root, sign waits for the quotient
    always_ff @(posedge clk) begin
      if (en) begin
        magd_r[l][0] <= mag1_r[l];
        sgnd_r[l][0] <= sgn1_r[l];
        for (int i = 0; i < SQRT_LAT; i++) magd_r[l][i+1] <= magd_r[l][i];
        for (int i = 0; i < MID; i++) sgnd_r[l][i+1] <= sgnd_r[l][i];
      end
    end

    vn_div_lane u_div (
      .clk (clk),
      .en  (en),
      .mag (magd_r[l][SQRT_LAT]),
      .len (len),
      .quo (quo[l])
    );

    // restore sign, force zero for the null vector
    always_comb begin
      if (zerod_r[MID-1])
        out_data_nxt[l*COMP_W +: COMP_W] = '0;
      else if (sgnd_r[l][MID])
        out_data_nxt[l*COMP_W +: COMP_W] = -COMP_W'(quo[l]);
      else
        out_data_nxt[l*COMP_W +: COMP_W] = COMP_W'(quo[l]);
    end
  end

  // merge: sum of squares and zero detect
  always_ff @(posedge clk) begin
    if (en) begin
      sum2_r  <= sq1_r[0] + sq1_r[1] + sq1_r[2];
      zero2_r <= (mag1_r[0] == '0) && (mag1_r[1] == '0) && (mag1_r[2] == '0);
    end
  end

  // zero flag follows the sum, so its chain is one stage shorter than the sign's
  always_ff @(posedge clk) begin
    if (en) begin
      zerod_r[0] <= zero2_r;
      for (int i = 0; i < MID - 1; i++) zerod_r[i+1] <= zerod_r[i];
    end
  end

  vn_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .sum  (sum2_r),
    .root (len)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_zero_r <= zerod_r[MID-1];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;
endmodule

>>> test/vector3_normalize_checker.sv
// ---------------------------------------------------------------------------
// vector3_normalize_checker
// Watches both streams of the normalizer, computes the expected unit vector
// for every accepted input beat and compares it with each output beat.
// ---------------------------------------------------------------------------
module vector3_normalize_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // comp_x[15:0], comp_y[31:16], comp_z[47:32]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // unit_x[15:0], unit_y[31:16], unit_z[47:32]
  input  logic        out_tuser,  // zero_length
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        zero_length;
    logic [15:0] unit_z;
    logic [15:0] unit_y;
    logic [15:0] unit_x;
  } unit_vec_t;

  unit_vec_t unit_queue[$];

  // floor square root, one result bit per step
  function automatic longint unsigned floor_root(longint unsigned s);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= root + b) begin
        s = s - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // rounded q2.14 quotient, ties away from zero
  function automatic logic [15:0] q14_divide(logic signed [15:0] c, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (c < 0) ? longint'(-int'(c)) : longint'(c);
    q = (mag * 32768 + len) / (2 * len);
    if (c < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic unit_vec_t normalize(logic [47:0] d);
    logic signed [15:0] x, y, z;
    longint unsigned sum, len;
    unit_vec_t r;
    x = d[15:0];
    y = d[31:16];
    z = d[47:32];
    sum = longint'(int'(x) * int'(x)) + longint'(int'(y) * int'(y))
        + longint'(int'(z) * int'(z));
    len = floor_root(sum);
    if (len == 0) begin
      r = '0;
      r.zero_length = 1'b1;
    end else begin
      r.unit_x = q14_divide(x, len);
      r.unit_y = q14_divide(y, len);
      r.unit_z = q14_divide(z, len);
      r.zero_length = 1'b0;
    end
    return r;
  endfunction

  assign pending = unit_queue.size();

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    unit_vec_t want;
    unit_vec_t got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) unit_queue.push_back(normalize(in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (unit_queue.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = unit_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch x/y/z/zero expected %h %h %h %b actual %h %h %h %b",
                     $time, want.unit_x, want.unit_y, want.unit_z, want.zero_length,
                     got.unit_x, got.unit_y, got.unit_z, got.zero_length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> test/vector3_normalize_test.sv
// ---------------------------------------------------------------------------
// vector3_normalize_test
// Drives directed and random vectors into the normalizer with random gaps
// and back pressure; the checker predicts and compares every output beat.
// ---------------------------------------------------------------------------
module vector3_normalize_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 500;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // comp_x[15:0], comp_y[31:16], comp_z[47:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // unit_x[15:0], unit_y[31:16], unit_z[47:32]
  logic        out_tuser;       // zero_length
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;     // no idling on either side
  int          idle_cycles = 0;

  always #6 clk = ~clk;

  vector3_normalize dut (.*);

  vector3_normalize_checker checker_i (.*);

  // receiver back pressure
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 32);
  end

  // watchdog on cycles with no beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(4))
      0: return 16'h8000 + 16'($urandom_range(3));
      1: return 16'h7fff - 16'($urandom_range(3));
      2: return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic [15:0] a, b, c;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, axis extremes, full-scale and tiny vectors
    send_vec(16'h0000, 16'h0000, 16'h0000);
    send_vec(16'h7fff, 16'h0000, 16'h0000);
    send_vec(16'h8000, 16'h0000, 16'h0000);
    send_vec(16'h0000, 16'h7fff, 16'h0000);
    send_vec(16'h0000, 16'h8000, 16'h0000);
    send_vec(16'h0000, 16'h0000, 16'h7fff);
    send_vec(16'h0000, 16'h0000, 16'h8000);
    send_vec(16'h8000, 16'h8000, 16'h8000);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff);
    send_vec(16'h8000, 16'h7fff, 16'h8000);
    send_vec(16'h0001, 16'h0000, 16'h0000);
    send_vec(16'hffff, 16'h0000, 16'h0000);
    send_vec(16'h0001, 16'h0001, 16'h0001);
    send_vec(16'hffff, 16'h0001, 16'hffff);
    send_vec(16'h0003, 16'h0004, 16'h0000);
    send_vec(16'h0002, 16'hfffd, 16'h0006);
    send_vec(16'h0001, 16'h0001, 16'h0000);

    // random part, with a stretch of no idling in the middle
    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = (i >= 200 && i < 300);
      a = rand_comp();
      b = rand_comp();
      c = rand_comp();
      send_vec(a, b, c);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/vn_pkg.sv
rtl/vn_sqrt.sv
rtl/vn_div_lane.sv
rtl/vector3_normalize.sv
test/vector3_normalize_checker.sv
test/vector3_normalize_test.sv
